[hw/rtl/tccs_pkg.sv]
// ----------------------------------------------------------------------------
// tccs_pkg
// shared types and codes of the text console engine
// ----------------------------------------------------------------------------
package tccs_pkg;

    // command codes
    localparam logic [2:0] CMD_PUT    = 3'd0;
    localparam logic [2:0] CMD_STREAM = 3'd1;
    localparam logic [2:0] CMD_ATTR   = 3'd2;
    localparam logic [2:0] CMD_FG     = 3'd3;
    localparam logic [2:0] CMD_BG     = 3'd4;
    localparam logic [2:0] CMD_MOVE   = 3'd5;
    localparam logic [2:0] CMD_CLEAR  = 3'd6;
    localparam logic [2:0] CMD_SCROLL = 3'd7;

    // memory operation codes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_FILL  = 3'd1;
    localparam logic [2:0] OP_COPY  = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;
    localparam logic [2:0] OP_NONE  = 3'd5;

    // attribute bit modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;
    localparam logic [1:0] MODE_KEEP   = 2'd3;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] FG_KEEP    = 8'hF8;
    localparam logic [7:0] BG_KEEP    = 8'h8F;
    localparam logic [7:0] ATTR_BLINK = 8'h80;
    localparam logic [7:0] BRIGHT_BIT = 8'h08;

    typedef enum logic [2:0] {
        CLS_VISIBLE,
        CLS_CR,
        CLS_LF,
        CLS_NUL,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] ch;
        cls_t       cls;
        logic       first;
        logic [1:0] blink;
        logic [1:0] hl;
        logic [6:0] col;
        logic [4:0] row;
        logic [5:0] lines;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] dest;
        logic [13:0] src;
        logic [13:0] count;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic        is_move;
        logic [6:0]  mv_x;
        logic [4:0]  mv_y;
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NONE,
        ST_CR_MOVE,
        ST_CR_INS,
        ST_WRITE,
        ST_MV_ADV,
        ST_MV_TAIL,
        ST_MOVE,
        ST_SC_DEC,
        ST_SC_FILL,
        ST_SC_START,
        ST_SC_COPY,
        ST_SC_FILL0,
        ST_SC_START0,
        ST_SC_MOVE,
        ST_CL_START,
        ST_CL_FILL,
        ST_CL_MOVE
    } seq_state_t;

    function automatic cls_t classify(input logic [7:0] ch);
        cls_t c;
        if (ch >= CH_SPACE && ch <= CH_TILDE) begin
            c = CLS_VISIBLE;
        end else if (ch == CH_CR) begin
            c = CLS_CR;
        end else if (ch == CH_LF) begin
            c = CLS_LF;
        end else if (ch == CH_NUL) begin
            c = CLS_NUL;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

    function automatic logic [7:0] apply_mode(input logic [7:0] attr,
                                              input logic [1:0] mode,
                                              input logic [7:0] mask);
        logic [7:0] r;
        unique case (mode)
            MODE_CLEAR:  r = attr & ~mask;
            MODE_SET:    r = attr | mask;
            MODE_TOGGLE: r = attr ^ mask;
            default:     r = attr;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/tccs_front.sv]
// ----------------------------------------------------------------------------
// tccs_front
// accepts command words, classifies the character and queues them
// ----------------------------------------------------------------------------
module tccs_front
    import tccs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_char_code,
    input  logic       s_first_of_string,
    input  logic [1:0] s_blink_mode,
    input  logic [1:0] s_highlight_mode,
    input  logic [6:0] s_column,
    input  logic [4:0] s_row,
    input  logic [5:0] s_line_count,
    output logic       head_valid,
    output item_t      head,
    input  logic       pop
);

    item_t      queue_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      entry;

    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = queue_reg[rd_ptr_reg];

    always_comb begin
        entry.cmd   = s_command;
        entry.ch    = s_char_code;
        entry.cls   = classify(s_char_code);
        entry.first = s_first_of_string;
        entry.blink = s_blink_mode;
        entry.hl    = s_highlight_mode;
        entry.col   = s_column;
        entry.row   = s_row;
        entry.lines = s_line_count;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[hw/rtl/tccs_back.sv]
// ----------------------------------------------------------------------------
// tccs_back
// console state and sequencer: turns one command into memory operations
// ----------------------------------------------------------------------------
module tccs_back
    import tccs_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int MEM_CELLS = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  item_t       head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_op_kind,
    output logic [13:0] m_dest_cell,
    output logic [13:0] m_src_cell,
    output logic [13:0] m_cell_count,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic        m_last
);

    localparam int PAGE_CELLS = COLUMNS * ROWS;
    localparam logic [13:0] PAGE14  = 14'(PAGE_CELLS);
    localparam logic [6:0]  LASTCOL = 7'(COLUMNS - 1);
    localparam logic [4:0]  LASTROW = 5'(ROWS - 1);

    seq_state_t  state_reg, state_next;
    logic [13:0] start_reg;
    logic [6:0]  col_reg;
    logic [4:0]  row_reg;
    logic [7:0]  attr_reg, prev_reg, ch_reg;
    logic        stopped_reg, tail_reg, tail_zero_reg;
    logic [6:0]  icol_reg;
    logic [4:0]  irow_reg;
    logic [5:0]  lines_reg;
    logic [13:0] span_reg, target_reg;

    logic        m_valid_reg, m_last_reg;
    logic [2:0]  m_kind_reg;
    logic [13:0] m_dest_reg, m_src_reg, m_count_reg;
    logic [7:0]  m_char_reg, m_attr_reg;

    logic        adv, emit, stopped_n, lf_bottom;
    logic [13:0] span_c;
    logic [14:0] target_c;
    logic        fits;
    op_t         op;
    seq_state_t  put_entry, lf_entry;

    function automatic logic [13:0] cell_addr(input logic [13:0] st,
                                              input logic [6:0] x,
                                              input logic [4:0] y);
        return st + 14'(y) * 14'(COLUMNS) + 14'(x);
    endfunction

    assign adv  = !m_valid_reg || m_ready;
    assign emit = adv && (state_reg != ST_IDLE) && (state_reg != ST_SC_DEC);
    assign pop  = (state_reg == ST_IDLE) && head_valid;

    assign stopped_n = !head.first && stopped_reg;
    assign lf_bottom = (row_reg == LASTROW);
    assign lf_entry  = lf_bottom ? ST_SC_DEC : ST_MV_TAIL;

    assign span_c   = 14'(lines_reg) * 14'(COLUMNS);
    assign target_c = {1'b0, start_reg} + {1'b0, span_c};
    assign fits     = (16'(target_c) + 16'(PAGE_CELLS)) <= 16'(MEM_CELLS);

    always_comb begin
        case (head.cls)
            CLS_VISIBLE: put_entry = ST_WRITE;
            CLS_CR:      put_entry = ST_CR_MOVE;
            CLS_LF:      put_entry = lf_entry;
            default:     put_entry = ST_NONE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    unique case (head.cmd)
                        CMD_PUT: state_next = put_entry;
                        CMD_STREAM: begin
                            if (stopped_n || head.cls == CLS_NUL) begin
                                state_next = ST_NONE;
                            end else if (head.cls == CLS_LF &&
                                         (head.first || prev_reg != CH_CR)) begin
                                state_next = ST_CR_INS;
                            end else begin
                                state_next = put_entry;
                            end
                        end
                        CMD_MOVE:   state_next = ST_MOVE;
                        CMD_CLEAR:  state_next = ST_CL_START;
                        CMD_SCROLL: state_next = (head.lines == 6'd0) ? ST_NONE : ST_SC_DEC;
                        default:    state_next = ST_NONE;
                    endcase
                end
            end
            ST_SC_DEC: begin
                if (lines_reg > {1'b0, row_reg}) begin
                    state_next = ST_CL_START;
                end else begin
                    state_next = fits ? ST_SC_FILL : ST_SC_COPY;
                end
            end
            default: begin
                if (adv) begin
                    unique case (state_reg)
                        ST_CR_INS: state_next = lf_entry;
                        ST_WRITE: begin
                            if (col_reg != LASTCOL) begin
                                state_next = ST_MV_ADV;
                            end else begin
                                state_next = lf_entry;
                            end
                        end
                        ST_SC_FILL:   state_next = ST_SC_START;
                        ST_SC_START:  state_next = tail_reg ? ST_MV_TAIL : ST_IDLE;
                        ST_SC_COPY:   state_next = ST_SC_FILL0;
                        ST_SC_FILL0:  state_next = ST_SC_START0;
                        ST_SC_START0: state_next = ST_SC_MOVE;
                        ST_SC_MOVE:   state_next = tail_reg ? ST_MV_TAIL : ST_IDLE;
                        ST_CL_START:  state_next = ST_CL_FILL;
                        ST_CL_FILL:   state_next = ST_CL_MOVE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // operation of the current step
    always_comb begin
        op         = '0;
        op.kind    = OP_CURSOR;
        op.is_move = 1'b1;
        op.mv_x    = col_reg;
        op.mv_y    = row_reg;
        unique case (state_reg)
            ST_CR_MOVE, ST_CR_INS: op.mv_x = 7'd0;
            ST_MV_ADV: op.mv_x = col_reg + 7'd1;
            ST_MV_TAIL: begin
                op.mv_x = tail_zero_reg ? 7'd0 : col_reg;
                op.mv_y = row_reg + 5'd1;
            end
            ST_MOVE: begin
                op.mv_x = (icol_reg < 7'(COLUMNS)) ? icol_reg : LASTCOL;
                op.mv_y = (irow_reg <= LASTROW) ? irow_reg : LASTROW;
            end
            ST_SC_MOVE: begin
            end
            ST_CL_MOVE: begin
                op.mv_x = 7'd0;
                op.mv_y = 5'd0;
            end
            ST_WRITE: begin
                op.is_move = 1'b0;
                op.kind    = OP_WRITE;
                op.ch      = ch_reg;
                op.attr    = attr_reg;
            end
            ST_SC_FILL: begin
                op.is_move = 1'b0;
                op.kind    = OP_FILL;
                op.count   = span_reg;
            end
            ST_SC_START: begin
                op.is_move = 1'b0;
                op.kind    = OP_START;
            end
            ST_SC_COPY: begin
                op.is_move = 1'b0;
                op.kind    = OP_COPY;
                op.src     = target_reg;
                op.count   = PAGE14 - span_reg;
            end
            ST_SC_FILL0: begin
                op.is_move = 1'b0;
                op.kind    = OP_FILL;
                op.count   = span_reg;
            end
            ST_SC_START0: begin
                op.is_move = 1'b0;
                op.kind    = OP_START;
            end
            ST_CL_START: begin
                op.is_move = 1'b0;
                op.kind    = OP_START;
            end
            ST_CL_FILL: begin
                op.is_move = 1'b0;
                op.kind    = OP_FILL;
                op.count   = PAGE14;
            end
            default: begin
                op.is_move = 1'b0;
                op.kind    = OP_NONE;
            end
        endcase
        // destinations
        case (state_reg)
            ST_WRITE:     op.dest = cell_addr(start_reg, col_reg, row_reg);
            ST_SC_FILL:   op.dest = start_reg + PAGE14;
            ST_SC_START:  op.dest = target_reg;
            ST_SC_COPY:   op.dest = 14'd0;
            ST_SC_FILL0:  op.dest = PAGE14 - span_reg;
            ST_SC_START0: op.dest = 14'd0;
            ST_CL_START: begin
                if ((16'(start_reg) + 16'(2 * PAGE_CELLS)) <= 16'(MEM_CELLS)) begin
                    op.dest = start_reg + PAGE14;
                end else begin
                    op.dest = 14'd0;
                end
            end
            ST_CL_FILL:   op.dest = start_reg;
            ST_NONE:      op.dest = 14'd0;
            default:      op.dest = cell_addr(start_reg, op.mv_x, op.mv_y);
        endcase
    end

    // console state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 14'd0;
            col_reg     <= 7'd0;
            row_reg     <= 5'd0;
            attr_reg    <= ATTR_RESET;
            prev_reg    <= CH_NUL;
            stopped_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                unique case (head.cmd)
                    CMD_STREAM: begin
                        stopped_reg <= stopped_n || head.cls == CLS_NUL;
                        if (!stopped_n && head.cls != CLS_NUL) begin
                            prev_reg <= head.ch;
                        end
                    end
                    CMD_ATTR: attr_reg <= head.ch;
                    CMD_FG: begin
                        attr_reg <= apply_mode(apply_mode((attr_reg & FG_KEEP) |
                                                          {5'd0, head.ch[2:0]},
                                                          head.blink, ATTR_BLINK),
                                               head.hl, BRIGHT_BIT);
                    end
                    CMD_BG: attr_reg <= (attr_reg & BG_KEEP) | {1'b0, head.ch[2:0], 4'd0};
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_SC_DEC && !(lines_reg > {1'b0, row_reg})) begin
                row_reg <= row_reg - lines_reg[4:0];
            end
            if (emit && op.is_move) begin
                col_reg <= op.mv_x;
                row_reg <= op.mv_y;
            end
            if (emit && op.kind == OP_START) begin
                start_reg <= op.dest;
            end
        end
    end

    // per-command working registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            ch_reg        <= head.ch;
            icol_reg      <= head.col;
            irow_reg      <= head.row;
            lines_reg     <= (head.cmd == CMD_SCROLL) ? head.lines : 6'd1;
            tail_reg      <= (head.cmd == CMD_PUT) || (head.cmd == CMD_STREAM);
            tail_zero_reg <= 1'b0;
        end else if (emit && state_reg == ST_WRITE) begin
            tail_zero_reg <= 1'b1;
        end
        if (state_reg == ST_SC_DEC) begin
            span_reg   <= span_c;
            target_reg <= target_c[13:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind_reg  <= op.kind;
            m_dest_reg  <= op.dest;
            m_src_reg   <= op.src;
            m_count_reg <= op.count;
            m_char_reg  <= op.ch;
            m_attr_reg  <= op.attr;
            m_last_reg  <= (state_next == ST_IDLE);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_op_kind    = m_kind_reg;
    assign m_dest_cell  = m_dest_reg;
    assign m_src_cell   = m_src_reg;
    assign m_cell_count = m_count_reg;
    assign m_cell_char  = m_char_reg;
    assign m_cell_attr  = m_attr_reg;
    assign m_last       = m_last_reg;

`ifndef ASSERT_OFF
    a_cursor_in_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < 7'(COLUMNS)) && (row_reg <= LASTROW))
        else $error("cursor left the page");

    a_page_in_memory: assert property (@(posedge aclk) disable iff (!aresetn)
        (16'(start_reg) + 16'(PAGE_CELLS)) <= 16'(MEM_CELLS))
        else $error("display page passes memory end");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && (state_next == ST_IDLE) |=> (state_reg == ST_IDLE) && m_last)
        else $error("last word did not end the command");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg != ST_IDLE) && !$stable(state_reg))
        else $error("popped command did not start a sequence");
`endif

endmodule

[hw/rtl/text_console_cursor_scroll.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// text console engine over a circular character-cell video memory
// ----------------------------------------------------------------------------
// usage:
//  s_ channel takes one command word (put or stream a character, attribute
//  and colour changes, cursor move, clear, scroll down) per valid/ready
//  handshake. a two-entry queue sits behind s_ready, so new words are taken
//  while the sequencer is still working on earlier ones.
//  m_ channel gives the memory operations each command causes, one word per
//  handshake, in order; m_last marks the final word of a command. commands
//  that touch no memory give a single op_kind none word.
//  sequencing: a dispatch step takes each command from the queue, then the
//  sequencer gives its result words; a scroll adds a decision step that
//  gives no word. the next command is taken only once the last word of the
//  current one is registered. the single output register of the sequencer
//  gives one result word per cycle while the receiver does not stall.
//  receiver stall: the result register holds and the sequencer waits; the
//  queue keeps filling until s_ready drops.
//  reset (aresetn low, synchronous): display start 0, cursor 0,0, attribute
//  0x07, stream state cleared, queue empty, no result pending.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int MEM_CELLS = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_char_code,
    input  logic        s_first_of_string,
    input  logic [1:0]  s_blink_mode,
    input  logic [1:0]  s_highlight_mode,
    input  logic [6:0]  s_column,
    input  logic [4:0]  s_row,
    input  logic [5:0]  s_line_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_op_kind,
    output logic [13:0] m_dest_cell,
    output logic [13:0] m_src_cell,
    output logic [13:0] m_cell_count,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic        m_last
);

    // queue head toward the sequencer
    logic  head_valid;
    item_t head;
    logic  pop;

    // front: accept, classify the character, queue
    tccs_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_char_code       (s_char_code),
        .s_first_of_string (s_first_of_string),
        .s_blink_mode      (s_blink_mode),
        .s_highlight_mode  (s_highlight_mode),
        .s_column          (s_column),
        .s_row             (s_row),
        .s_line_count      (s_line_count),
        .head_valid        (head_valid),
        .head              (head),
        .pop               (pop)
    );

    // back: console state, operation sequencer and result register
    tccs_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .MEM_CELLS (MEM_CELLS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_op_kind    (m_op_kind),
        .m_dest_cell  (m_dest_cell),
        .m_src_cell   (m_src_cell),
        .m_cell_count (m_cell_count),
        .m_cell_char  (m_cell_char),
        .m_cell_attr  (m_cell_attr),
        .m_last       (m_last)
    );

endmodule

[verif/tccs_checker.sv]
// ----------------------------------------------------------------------------
// tccs_checker
// watches both channels of the text console engine, predicts the memory
// operations of each accepted command word and compares them in order
// ----------------------------------------------------------------------------
module tccs_checker
    import tccs_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int MEM_CELLS = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_char_code,
    input  logic        s_first_of_string,
    input  logic [1:0]  s_blink_mode,
    input  logic [1:0]  s_highlight_mode,
    input  logic [6:0]  s_column,
    input  logic [4:0]  s_row,
    input  logic [5:0]  s_line_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_op_kind,
    input  logic [13:0] m_dest_cell,
    input  logic [13:0] m_src_cell,
    input  logic [13:0] m_cell_count,
    input  logic [7:0]  m_cell_char,
    input  logic [7:0]  m_cell_attr,
    input  logic        m_last,
    output int          fail_count,
    output int          ops_pending,
    output int          ops_checked,
    output int          wrap_scrolls
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE = COLUMNS * ROWS;

    typedef struct {
        logic [2:0]  kind;
        logic [13:0] dest;
        logic [13:0] src;
        logic [13:0] count;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic        last;
    } mem_op_t;

    mem_op_t pending_ops[$];
    mem_op_t word_ops[6];
    int      n_word_ops;

    // console state
    int         disp_start;
    int         cur_col;
    int         cur_row;
    logic [7:0] attr_byte;
    logic [7:0] prev_char;
    logic       stopped;

    initial begin
        fail_count   = 0;
        ops_checked  = 0;
        wrap_scrolls = 0;
    end

    assign ops_pending = pending_ops.size();

    task automatic add_op(input logic [2:0] kind, input int dest, input int src,
                          input int count, input logic [7:0] ch,
                          input logic [7:0] attr);
        if (n_word_ops < 6) begin
            word_ops[n_word_ops] = '{kind, dest[13:0], src[13:0], count[13:0],
                                     ch, attr, 1'b0};
            n_word_ops++;
        end
    endtask

    task automatic set_start(input int pos);
        disp_start = pos & 16'h3FFF;
        add_op(OP_START, disp_start, 0, 0, 8'h0, 8'h0);
    endtask

    task automatic move_cursor(input int x, input int y);
        cur_col = (x < COLUMNS) ? x : COLUMNS - 1;
        cur_row = (y <= ROWS - 1) ? y : ROWS - 1;
        add_op(OP_CURSOR, disp_start + cur_row * COLUMNS + cur_col, 0, 0, 8'h0, 8'h0);
    endtask

    task automatic clear_page();
        if (disp_start + 2 * PAGE <= MEM_CELLS) set_start(disp_start + PAGE);
        else set_start(0);
        add_op(OP_FILL, disp_start, 0, PAGE, 8'h0, 8'h0);
        move_cursor(0, 0);
    endtask

    task automatic scroll_lines(input int lines);
        int span;
        int target;
        if (lines == 0) return;
        if (lines > cur_row) begin
            clear_page();
            return;
        end
        cur_row -= lines;
        span = lines * COLUMNS;
        target = disp_start + span;
        if (target + PAGE <= MEM_CELLS) begin
            add_op(OP_FILL, disp_start + PAGE, 0, span, 8'h0, 8'h0);
            set_start(target);
        end else begin
            // kept lines go back to cell 0
            wrap_scrolls++;
            add_op(OP_COPY, 0, target, PAGE - span, 8'h0, 8'h0);
            add_op(OP_FILL, PAGE - span, 0, span, 8'h0, 8'h0);
            set_start(0);
            move_cursor(cur_col, cur_row);
        end
    endtask

    task automatic put_glyph(input logic [7:0] ch);
        if (ch >= CH_SPACE && ch <= CH_TILDE) begin
            add_op(OP_WRITE, disp_start + cur_row * COLUMNS + cur_col, 0, 0, ch, attr_byte);
            if (cur_col + 1 < COLUMNS) begin
                move_cursor(cur_col + 1, cur_row);
            end else begin
                if (cur_row + 1 == ROWS) scroll_lines(1);
                move_cursor(0, cur_row + 1);
            end
        end else if (ch == CH_CR) begin
            move_cursor(0, cur_row);
        end else if (ch == CH_LF) begin
            if (cur_row + 1 == ROWS) scroll_lines(1);
            move_cursor(cur_col, cur_row + 1);
        end
    endtask

    function automatic logic [7:0] bit_mode(input logic [7:0] a, input logic [1:0] mode,
                                            input logic [7:0] mask);
        case (mode)
            MODE_CLEAR:  return a & ~mask;
            MODE_SET:    return a | mask;
            MODE_TOGGLE: return a ^ mask;
            default:     return a;
        endcase
    endfunction

    task automatic predict_word();
        logic [7:0] a;
        n_word_ops = 0;
        case (s_command)
            CMD_PUT: put_glyph(s_char_code);
            CMD_STREAM: begin
                if (s_first_of_string) stopped = 1'b0;
                if (!stopped) begin
                    if (s_char_code == CH_NUL) begin
                        stopped = 1'b1;
                    end else begin
                        if (s_char_code == CH_LF && (s_first_of_string || prev_char != CH_CR))
                            put_glyph(CH_CR);
                        put_glyph(s_char_code);
                        prev_char = s_char_code;
                    end
                end
            end
            CMD_ATTR: attr_byte = s_char_code;
            CMD_FG: begin
                a = (attr_byte & FG_KEEP) | (s_char_code & ~FG_KEEP);
                a = bit_mode(a, s_blink_mode, ATTR_BLINK);
                attr_byte = bit_mode(a, s_highlight_mode, BRIGHT_BIT);
            end
            CMD_BG: attr_byte = (attr_byte & BG_KEEP) | {1'b0, s_char_code[2:0], 4'h0};
            CMD_MOVE: move_cursor(s_column, s_row);
            CMD_CLEAR: clear_page();
            default: scroll_lines(s_line_count);
        endcase
        if (n_word_ops == 0) add_op(OP_NONE, 0, 0, 0, 8'h0, 8'h0);
        word_ops[n_word_ops - 1].last = 1'b1;
        for (int i = 0; i < n_word_ops; i++) pending_ops.push_back(word_ops[i]);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        mem_op_t e;
        if (!aresetn) begin
            disp_start = 0;
            cur_col    = 0;
            cur_row    = 0;
            attr_byte  = ATTR_RESET;
            prev_char  = CH_NUL;
            stopped    = 1'b0;
        end else begin
            if (s_valid && s_ready) predict_word();
            if (m_valid && m_ready) begin
                ops_checked++;
                if (pending_ops.size() == 0) begin
                    report("unexpected word kind", m_op_kind, -1);
                end else begin
                    e = pending_ops.pop_front();
                    if (m_op_kind !== e.kind) report("op_kind", m_op_kind, e.kind);
                    if (m_dest_cell !== e.dest) report("dest_cell", m_dest_cell, e.dest);
                    if (m_src_cell !== e.src) report("src_cell", m_src_cell, e.src);
                    if (m_cell_count !== e.count) report("cell_count", m_cell_count, e.count);
                    if (m_cell_char !== e.ch) report("cell_char", m_cell_char, e.ch);
                    if (m_cell_attr !== e.attr) report("cell_attr", m_cell_attr, e.attr);
                    if (m_last !== e.last) report("last", m_last, e.last);
                end
            end
        end
    end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the text console engine; a checker beside the
// block predicts and compares every memory operation word
// ----------------------------------------------------------------------------
module tb_top;
    import tccs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 300000;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] ch;
        logic       first;
        logic [1:0] blink;
        logic [1:0] hl;
        logic [6:0] col;
        logic [4:0] row;
        logic [5:0] lines;
    } cmd_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = '0;
    logic [7:0]  s_char_code = '0;
    logic        s_first_of_string = 1'b0;
    logic [1:0]  s_blink_mode = '0;
    logic [1:0]  s_highlight_mode = '0;
    logic [6:0]  s_column = '0;
    logic [4:0]  s_row = '0;
    logic [5:0]  s_line_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_op_kind;
    logic [13:0] m_dest_cell;
    logic [13:0] m_src_cell;
    logic [13:0] m_cell_count;
    logic [7:0]  m_cell_char;
    logic [7:0]  m_cell_attr;
    logic        m_last;

    int fail_count;
    int ops_pending;
    int ops_checked;
    int wrap_scrolls;
    int words_sent = 0;
    int cycles = 0;

    // idling on or off for both sides; long receiver hold requested once
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;
    logic pause_done = 1'b0;

    always #6 aclk = ~aclk;

    text_console_cursor_scroll u_dut (.*);

    tccs_checker u_chk (.*);

    // timeout guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold counted here
    initial begin
        int  stall_left;
        logic hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                // long hold so the input queue fills and s_ready drops
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (200) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= (stall_left == 0);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one word and hold it until taken, then maybe a gap
    task automatic send_word(input cmd_word_t w);
        s_valid           <= 1'b1;
        s_command         <= w.cmd;
        s_char_code       <= w.ch;
        s_first_of_string <= w.first;
        s_blink_mode      <= w.blink;
        s_highlight_mode  <= w.hl;
        s_column          <= w.col;
        s_row             <= w.row;
        s_line_count      <= w.lines;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    endtask

    // every field random, so unused fields toggle too
    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        w.cmd   = 3'($urandom_range(0, 7));
        w.ch    = 8'($urandom_range(0, 255));
        w.first = 1'($urandom_range(0, 1));
        w.blink = 2'($urandom_range(0, 3));
        w.hl    = 2'($urandom_range(0, 3));
        w.col   = 7'($urandom_range(0, 127));
        w.row   = 5'($urandom_range(0, 31));
        w.lines = 6'($urandom_range(0, 63));
        return w;
    endfunction

    function automatic cmd_word_t mk(input logic [2:0] cmd, input logic [7:0] ch);
        cmd_word_t w;
        w = rand_word();
        w.cmd = cmd;
        w.ch  = ch;
        return w;
    endfunction

    // printable text mostly, some CR/LF, rare junk bytes
    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 8'($urandom_range(CH_SPACE, CH_TILDE));
        if (r < 88) return CH_LF;
        if (r < 94) return CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        cmd_word_t w;
        int n;
        int len;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: character classes at the edges
        send_word(mk(CMD_PUT, CH_SPACE));
        send_word(mk(CMD_PUT, CH_TILDE));
        send_word(mk(CMD_PUT, 8'h1F));
        send_word(mk(CMD_PUT, 8'hFF));
        send_word(mk(CMD_PUT, CH_CR));
        send_word(mk(CMD_PUT, CH_LF));
        // attribute commands with every mode
        send_word(mk(CMD_ATTR, 8'hFF));
        w = mk(CMD_FG, 8'h07); w.blink = MODE_SET; w.hl = MODE_CLEAR; send_word(w);
        w = mk(CMD_FG, 8'hF8); w.blink = MODE_TOGGLE; w.hl = MODE_TOGGLE; send_word(w);
        w = mk(CMD_FG, 8'h00); w.blink = MODE_KEEP; w.hl = MODE_SET; send_word(w);
        w = mk(CMD_FG, 8'h05); w.blink = MODE_CLEAR; w.hl = MODE_KEEP; send_word(w);
        send_word(mk(CMD_BG, 8'hFF));
        // move clamped to the far corner
        w = mk(CMD_MOVE, 8'h00); w.col = 7'd127; w.row = 5'd31; send_word(w);
        // stream start with lone line feed, then stop and stopped char
        w = mk(CMD_STREAM, CH_LF); w.first = 1'b1; send_word(w);
        w = mk(CMD_STREAM, CH_NUL); w.first = 1'b0; send_word(w);
        w = mk(CMD_STREAM, 8'h41); w.first = 1'b0; send_word(w);
        // scroll by zero and beyond cursor row
        w = mk(CMD_SCROLL, 8'h00); w.lines = 6'd0; send_word(w);
        w = mk(CMD_SCROLL, 8'h00); w.lines = 6'd63; send_word(w);
        // clears walk the display start to the top of memory and wrap
        for (int i = 0; i < 7; i++) send_word(mk(CMD_CLEAR, 8'h00));
        // scroll of ten lines from the bottom row, which still fits in memory
        w = mk(CMD_MOVE, 8'h00); w.col = 7'd0; w.row = 5'd24; send_word(w);
        w = mk(CMD_SCROLL, 8'h00); w.lines = 6'd10; send_word(w);

        // random part: mostly streamed lines, with other commands mixed in
        n = 0;
        while (n < 380) begin
            if (n >= 100 && !hold_req) hold_req <= 1'b1;
            if (n >= 200 && !pause_done) begin
                // sender pause until everything is out
                pause_done = 1'b1;
                s_valid <= 1'b0;
                while (ops_pending != 0) @(negedge aclk);
            end
            if (n >= 320) idle_on <= 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 12);
                    for (int k = 0; k < len; k++) begin
                        w = mk(CMD_STREAM, text_char());
                        w.first = (k == 0) || ($urandom_range(0, 19) == 0);
                        if (k == len - 1 && $urandom_range(0, 1)) w.ch = CH_NUL;
                        send_word(w);
                        n++;
                    end
                end
                4, 5: begin
                    send_word(mk(CMD_PUT, text_char()));
                    n++;
                end
                6: begin
                    // bias toward the bottom rows so line feeds scroll
                    w = rand_word();
                    w.cmd = CMD_MOVE;
                    if ($urandom_range(0, 1)) w.row = 5'($urandom_range(20, 31));
                    send_word(w);
                    n++;
                end
                7: begin
                    w = rand_word();
                    w.cmd = CMD_SCROLL;
                    if ($urandom_range(0, 3) != 0) w.lines = 6'($urandom_range(0, 8));
                    send_word(w);
                    n++;
                end
                8: begin
                    w = rand_word();
                    w.cmd = ($urandom_range(0, 4) == 0) ? CMD_CLEAR
                          : 3'($urandom_range(CMD_ATTR, CMD_BG));
                    send_word(w);
                    n++;
                end
                default: begin
                    send_word(rand_word());
                    n++;
                end
            endcase
        end
        s_valid <= 1'b0;

        while (ops_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("sent %0d command words, checked %0d memory operation words", words_sent,
                 ops_checked);
        $display("memory-end scroll wraps seen: %0d", wrap_scrolls);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_front.sv
hw/rtl/tccs_back.sv
hw/rtl/text_console_cursor_scroll.sv
verif/tccs_checker.sv
verif/tb_top.sv
